>>> hdl/retrieval_filter_mask_assert.svh
// Assertion macros used by the retrieval filter mask RTL.
`ifndef RETRIEVAL_FILTER_MASK_ASSERT_SVH
`define RETRIEVAL_FILTER_MASK_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define RFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("retrieval filter mask check failed");

// Next-cycle implication, clocked on clk, disabled during reset.
`define RFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("retrieval filter mask check failed");

`endif

>>> hdl/rfm_pkg.sv
// Package: types, constants and register codes of the retrieval filter mask.
`timescale 1ns / 1ps

package rfm_pkg;

  // token table geometry
  localparam int TABLE_WORDS = 2048;
  localparam int TBL_AW      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int TBL_DW      = 16;

  // configuration port geometry
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // time window value that lets every entry through (with start time zero)
  localparam logic [31:0] ALL_PASS_END = 32'h8000_0001;

  // half-precision bounds of the token test: 2.0 and +inf
  localparam logic [15:0] HALF_TWO = 16'h4000;
  localparam logic [15:0] HALF_INF = 16'h7C00;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TIME  = 4'd0,
    CFG_END_TIME    = 4'd1,
    CFG_FILTER_MASK = 4'd2,
    CFG_MATCH_MODE  = 4'd3
  } cfg_idx_t;

  // request types
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ENTRY = 1'b1
  } req_type_t;

  // attribute match modes
  typedef enum logic {
    MATCH_ALL     = 1'b0,
    MATCH_OVERLAP = 1'b1
  } match_mode_t;

  // entry state between the table read and the output register
  typedef struct packed {
    logic        time_ok;
    logic        attr_ok;
    logic        idx_ok;
    logic [15:0] token_bits;
  } rfm_s1_t;

endpackage

>>> hdl/rfm_in_if.sv
// Input channel interface: load and database entry transactions.
`timescale 1ns / 1ps

interface rfm_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [10:0]        table_index;
  logic [15:0]        table_word;
  logic signed [31:0] entry_time;
  logic [11:0]        token_offset;
  logic [15:0]        token_bits;
  logic signed [15:0] attr_bits;

  modport source (
    output valid, req_type, table_index, table_word, entry_time,
           token_offset, token_bits, attr_bits,
    input  ready
  );
  modport sink (
    input  valid, req_type, table_index, table_word, entry_time,
           token_offset, token_bits, attr_bits,
    output ready
  );
endinterface

>>> hdl/rfm_out_if.sv
// Result channel interface: one pass bit per entry transaction.
`timescale 1ns / 1ps

interface rfm_out_if;
  logic valid;
  logic ready;
  logic pass_bit;

  modport source (output valid, pass_bit, input ready);
  modport sink (input valid, pass_bit, output ready);
endinterface

>>> hdl/rfm_cfg_if.sv
// Configuration write channel interface.
`timescale 1ns / 1ps

interface rfm_cfg_if;
  import rfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> hdl/rfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/retrieval_filter_mask.sv
// Top level of the retrieval filter mask: config registers, table and pass pipeline.
`timescale 1ns / 1ps
`include "retrieval_filter_mask_assert.svh"

// Retrieval filter mask. Load transactions write one 16-bit word into the token
// table; entry transactions each return one pass bit (time, token and attribute
// tests ANDed). One transaction is taken per cycle unless stage 1 stalls, loads
// and entries mixed in any order; an entry waits in stage 1 for the token
// table's registered read port, and its pass bit then sits in the output register.
// A load that follows an entry never disturbs it, and an entry always sees every
// earlier load, since the table is written and read once per cycle at most. The
// table is not cleared after reset: reading a word never written gives an
// arbitrary token result. Configuration writes are taken in every cycle and
// should be issued only while no entry is in flight.
module retrieval_filter_mask
  import rfm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  rfm_in_if.sink  in_ch,
  rfm_out_if.source out_ch,
  rfm_cfg_if.sink cfg_ch
);

  // configuration registers
  logic [31:0] start_time_r;
  logic [31:0] end_time_r;
  logic [15:0] filter_mask_r;
  logic        match_mode_r;

  // pipeline control and payload
  logic        s1_valid_r, s1_valid_nxt;
  rfm_s1_t     s1_r, s1_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_pass_r, out_pass_nxt;

  logic        in_acc, entry_acc, load_acc;
  logic        s1_adv;
  logic [10:0] word_idx;
  logic        load_in_range;
  logic [15:0] ram_rdata;

  // entry tests; time and attribute tests evaluated at acceptance
  logic [31:0] lo_sum, hi_sum;
  logic        all_pass, win_empty, time_ok;
  logic [15:0] attr_and;
  logic        attr_ok;
  logic [15:0] token_and;
  logic        token_ok;

  assign cfg_ch.ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r  <= '0;
      end_time_r    <= ALL_PASS_END;
      filter_mask_r <= '0;
      match_mode_r  <= MATCH_ALL;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.idx)
        CFG_START_TIME:  start_time_r  <= cfg_ch.data[31:0];
        CFG_END_TIME:    end_time_r    <= cfg_ch.data[31:0];
        CFG_FILTER_MASK: filter_mask_r <= cfg_ch.data[15:0];
        CFG_MATCH_MODE:  match_mode_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or drains
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign entry_acc   = in_acc && (in_ch.req_type == REQ_ENTRY);
  assign load_acc    = in_acc && (in_ch.req_type == REQ_LOAD);

  assign word_idx      = in_ch.token_offset[11:1];
  assign load_in_range = (32'(in_ch.table_index) < TABLE_WORDS);

  // token table
  rfm_ram #(
    .WIDTH (TBL_DW),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk   (clk),
    .we    (load_acc && load_in_range),
    .waddr (TBL_AW'(in_ch.table_index)),
    .wdata (in_ch.table_word),
    .re    (entry_acc),
    .raddr (TBL_AW'(word_idx)),
    .rdata (ram_rdata)
  );

  // time window test, sums wrap at 32 bits
  always_comb begin
    lo_sum    = in_ch.entry_time + start_time_r;
    hi_sum    = in_ch.entry_time + end_time_r;
    all_pass  = (start_time_r == '0) && (end_time_r == ALL_PASS_END);
    win_empty = ($signed(start_time_r) < $signed(end_time_r));
    time_ok   = all_pass ||
                (!win_empty && !lo_sum[31] && (hi_sum[31] || (hi_sum == '0)));
  end

  // attribute test
  always_comb begin
    attr_and = filter_mask_r & in_ch.attr_bits;
    case (match_mode_r)
      MATCH_ALL:     attr_ok = (attr_and == filter_mask_r);
      MATCH_OVERLAP: attr_ok = (attr_and != '0) && !attr_and[15];
      default:       attr_ok = 1'b0;
    endcase
  end

  // stage 1: waits for table data
  always_comb begin
    s1_nxt            = s1_r;
    s1_valid_nxt      = s1_valid_r;
    if (entry_acc) begin
      s1_valid_nxt      = 1'b1;
      s1_nxt.time_ok    = time_ok;
      s1_nxt.attr_ok    = attr_ok;
      s1_nxt.idx_ok     = (32'(word_idx) < TABLE_WORDS);
      s1_nxt.token_bits = in_ch.token_bits;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // token test on table data, result into the output register
  always_comb begin
    token_and     = ram_rdata & s1_r.token_bits;
    token_ok      = s1_r.idx_ok && (token_and > HALF_TWO) && (token_and <= HALF_INF);
    out_valid_nxt = out_valid_r;
    out_pass_nxt  = out_pass_r;
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
      out_pass_nxt  = s1_r.time_ok && s1_r.attr_ok && token_ok;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_pass_r <= out_pass_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.pass_bit = out_pass_r;

  // checks
  `RFM_ASSERT_NEXT(a_entry_enters_s1, entry_acc, s1_valid_r)
  `RFM_ASSERT_NEXT(a_load_leaves_s1_empty, load_acc, !s1_valid_r)
  `RFM_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_r))
  `RFM_ASSERT_NEXT(a_bad_offset_fails, s1_valid_r && s1_adv && !s1_r.idx_ok,
                   out_valid_r && !out_pass_r)

endmodule
